[rtl/qr_payload_amount_insert_crc_core_macros.svh]
// Assertion helpers for the RTL core.
`ifndef QR_PAYLOAD_AMOUNT_INSERT_CRC_CORE_MACROS_SVH
`define QR_PAYLOAD_AMOUNT_INSERT_CRC_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define QPAIC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("qpaic assertion failed");

// Next-cycle implication, disabled in reset.
`define QPAIC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("qpaic assertion failed");

`endif

[rtl/qpaic_pkg.sv]
package qpaic_pkg;

    localparam int PRICE_W          = 34;
    localparam int MAX_PRICE_DIGITS = 10;
    // 2^34 - 1 needs at most 11 decimal digits
    localparam int BCD_DIGITS = (MAX_PRICE_DIGITS < 11) ? MAX_PRICE_DIGITS : 11;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int BIT_CNT_W  = $clog2(PRICE_W + 1);
    localparam int DCNT_W     = $clog2(BCD_DIGITS + 1);
    localparam int IDX_W      = $clog2(BCD_DIGITS + 4);
    localparam int HOLD_DEPTH = 3;

    localparam logic [47:0] CUR_PREFIX = 48'h353330333336;
    localparam logic [7:0]  CUR_FINAL  = 8'h30;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_1 = 8'h31;
    localparam logic [7:0] CH_3 = 8'h33;
    localparam logic [7:0] CH_4 = 8'h34;
    localparam logic [7:0] CH_5 = 8'h35;
    localparam logic [7:0] CH_6 = 8'h36;

    function automatic logic [63:0] calc_price_limit();
        logic [63:0] v;
        v = 64'd0;
        for (int i = 0; i < MAX_PRICE_DIGITS; i++) begin
            v = v * 64'd10 + 64'd9;
        end
        return v;
    endfunction

    localparam logic [63:0] PRICE_LIMIT = calc_price_limit();

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_CONV,
        ST_INS,
        ST_FLUSH,
        ST_TAIL,
        ST_HEX
    } state_t;

    typedef struct packed {
        logic              done;
        logic [DCNT_W-1:0] ndig;
    } bcd_stat_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] c);
        logic [15:0] v;
        v = crc ^ {c, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (v[15]) begin
                v = {v[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                v = {v[14:0], 1'b0};
            end
        end
        return v;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) begin
            r = CH_0 + {4'd0, n};
        end else begin
            r = 8'h37 + {4'd0, n};
        end
        return r;
    endfunction

    function automatic logic [7:0] tail_char(input logic [1:0] i);
        logic [7:0] r;
        case (i)
            2'd0:    r = CH_6;
            2'd1:    r = CH_3;
            2'd2:    r = CH_0;
            default: r = CH_4;
        endcase
        return r;
    endfunction

endpackage

[rtl/qpaic_bcd.sv]
module qpaic_bcd
    import qpaic_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [PRICE_W-1:0] price,
    output bcd_stat_t          stat,
    output logic [BCD_W-1:0]   bcd
);

    logic [PRICE_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [BIT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [PRICE_W-1:0]   sat_price;
    logic [BCD_W-1:0]     adj;
    logic [DCNT_W-1:0]    ndig;

    assign sat_price = ({{(64-PRICE_W){1'b0}}, price} > PRICE_LIMIT) ?
                       PRICE_LIMIT[PRICE_W-1:0] : price;

    // shift-add-3 step
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        cnt_next = cnt_reg;
        if (start) begin
            bin_next = sat_price;
            bcd_next = '0;
            cnt_next = BIT_CNT_W'(PRICE_W);
        end else if (cnt_reg != '0) begin
            bin_next = {bin_reg[PRICE_W-2:0], 1'b0};
            bcd_next = {adj[BCD_W-2:0], bin_reg[PRICE_W-1]};
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_comb begin
        ndig = DCNT_W'(1);
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] != 4'd0) begin
                ndig = DCNT_W'(i + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign stat.done = (cnt_reg == '0);
    assign stat.ndig = ndig;
    assign bcd       = bcd_reg;

endmodule

[rtl/qr_payload_amount_insert_crc_core.sv]
// Payload rewriter: inserts the amount tag after the first currency tag
// "5303360", cuts the stream at the first "6304" and appends "6304" plus
// four uppercase hex digits of CRC-16/CCITT-FALSE.
// Input channel s_*: one character per beat, s_in_last on the final one.
// Output channel m_*: one character per beat; m_out_last marks the last CRC
// digit, where m_status is 1 if no currency tag was seen.
// cfg_wr_en/cfg_wr_data set the price; write it only while idle.
// The beat that completes the currency tag also runs the binary to BCD
// converter, which shifts in each of the 34 price bits, and then emits
// 4 + digits amount characters, one per cycle when the output is not
// stalled. The final beat adds a flush of the hold buffer (up to 3
// characters), the 4 tag characters and the 4 CRC digits.
// s_ready is high only while the sequencer is idle.
// A single output register holds each result; when it is full and m_ready
// is low the sequencer stalls; a running BCD conversion and input in idle carry on.
// Reset (synchronous, aresetn low) clears price, match window, hold state
// and sets the CRC to 0xFFFF; no clearing pass is needed.
module qr_payload_amount_insert_crc_core
    import qpaic_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [PRICE_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_in_char,
    input  logic               s_in_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_char,
    output logic               m_out_last,
    output logic               m_status
);

`include "qr_payload_amount_insert_crc_core_macros.svh"

    state_t state_reg, state_next;

    logic [PRICE_W-1:0] price_reg, price_next;
    logic [47:0]        window_reg, window_next;
    logic               cur_seen_reg, cur_seen_next;
    logic               trunc_reg, trunc_next;
    logic [1:0]         hcnt_reg, hcnt_next;
    logic [7:0]         hold_reg [HOLD_DEPTH];
    logic [7:0]         hold_next [HOLD_DEPTH];
    logic [15:0]        crc_reg, crc_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [7:0]         char_reg, char_next;
    logic               last_reg, last_next;
    logic               hit_reg, hit_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_char_reg, out_char_next;
    logic               out_last_reg, out_last_next;
    logic               status_reg, status_next;

    logic               in_acc, adv, hit;
    logic               push_en, push_send;
    logic [7:0]         push_char;
    logic [7:0]         ph_next [HOLD_DEPTH];
    logic [1:0]         ph_cnt;
    logic               ph_trunc;
    logic               send_en, put_en, put_last, end_pkt;
    logic [7:0]         send_char, put_char;
    logic               bcd_start;
    bcd_stat_t          bcd_stat;
    logic [BCD_W-1:0]   bcd;
    logic [IDX_W-1:0]   ins_end, dpos;
    logic [7:0]         ins_char, dig_char;
    logic [DCNT_W-1:0]  ones;

    qpaic_bcd u_bcd (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (bcd_start),
        .price   (price_reg),
        .stat    (bcd_stat),
        .bcd     (bcd)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign in_acc  = s_valid && s_ready;
    assign adv     = !out_valid_reg || m_ready;
    assign hit     = !cur_seen_reg && (window_reg == CUR_PREFIX) && (s_in_char == CUR_FINAL);

    // amount characters: "54", two length digits, then digits MSB first
    assign ins_end = IDX_W'(bcd_stat.ndig) + IDX_W'(3);
    assign dpos    = ins_end - idx_reg;
    assign ones    = (bcd_stat.ndig >= DCNT_W'(10)) ? bcd_stat.ndig - DCNT_W'(10)
                                                    : bcd_stat.ndig;

    always_comb begin
        dig_char = CH_0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (dpos == IDX_W'(i)) begin
                dig_char = CH_0 + {4'd0, bcd[4*i +: 4]};
            end
        end
    end

    always_comb begin
        case (idx_reg)
            IDX_W'(0): ins_char = CH_5;
            IDX_W'(1): ins_char = CH_4;
            IDX_W'(2): ins_char = (bcd_stat.ndig >= DCNT_W'(10)) ? CH_1 : CH_0;
            IDX_W'(3): ins_char = CH_0 + 8'(ones);
            default:   ins_char = dig_char;
        endcase
    end

    // hold-back buffer with "6304" cut
    always_comb begin
        ph_next   = hold_reg;
        ph_cnt    = hcnt_reg;
        ph_trunc  = trunc_reg;
        push_send = 1'b0;
        if (push_en && !trunc_reg) begin
            if (hcnt_reg == 2'(HOLD_DEPTH)) begin
                if (hold_reg[0] == CH_6 && hold_reg[1] == CH_3 &&
                    hold_reg[2] == CH_0 && push_char == CH_4) begin
                    ph_trunc = 1'b1;
                    ph_cnt   = 2'd0;
                end else begin
                    push_send  = 1'b1;
                    ph_next[0] = hold_reg[1];
                    ph_next[1] = hold_reg[2];
                    ph_next[2] = push_char;
                end
            end else begin
                ph_next[hcnt_reg] = push_char;
                ph_cnt            = hcnt_reg + 2'd1;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) state_next = ST_PUSH;
            end
            ST_PUSH: begin
                if (adv) begin
                    if (hit_reg)       state_next = ST_CONV;
                    else if (last_reg) state_next = ST_FLUSH;
                    else               state_next = ST_IDLE;
                end
            end
            ST_CONV: begin
                if (bcd_stat.done) state_next = ST_INS;
            end
            ST_INS: begin
                if (adv && idx_reg == ins_end) begin
                    state_next = last_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_FLUSH: begin
                if (adv && hcnt_reg == 2'd0) state_next = ST_TAIL;
            end
            ST_TAIL: begin
                if (adv && idx_reg == IDX_W'(3)) state_next = ST_HEX;
            end
            ST_HEX: begin
                if (adv && idx_reg == IDX_W'(3)) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        push_en   = 1'b0;
        push_char = char_reg;
        send_en   = 1'b0;
        send_char = hold_reg[0];
        put_en    = 1'b0;
        put_char  = hex_char(crc_reg[15:12]);
        put_last  = 1'b0;
        end_pkt   = 1'b0;
        bcd_start = 1'b0;
        idx_next  = idx_reg;

        price_next    = cfg_wr_en ? cfg_wr_data : price_reg;
        window_next   = window_reg;
        cur_seen_next = cur_seen_reg;
        char_next     = char_reg;
        last_next     = last_reg;
        hit_next      = hit_reg;

        if (in_acc) begin
            char_next     = s_in_char;
            last_next     = s_in_last;
            hit_next      = hit;
            window_next   = {window_reg[39:0], s_in_char};
            cur_seen_next = cur_seen_reg || hit;
        end

        case (state_reg)
            ST_PUSH: begin
                if (adv) begin
                    push_en   = 1'b1;
                    bcd_start = hit_reg;
                end
            end
            ST_INS: begin
                if (adv) begin
                    push_en   = 1'b1;
                    push_char = ins_char;
                    idx_next  = (idx_reg == ins_end) ? '0 : idx_reg + 1'b1;
                end
            end
            ST_FLUSH: begin
                if (adv && hcnt_reg != 2'd0) send_en = 1'b1;
            end
            ST_TAIL: begin
                if (adv) begin
                    send_en   = 1'b1;
                    send_char = tail_char(idx_reg[1:0]);
                    idx_next  = (idx_reg == IDX_W'(3)) ? '0 : idx_reg + 1'b1;
                end
            end
            ST_HEX: begin
                if (adv) begin
                    put_en   = 1'b1;
                    put_char = hex_char(crc_reg[4*(3-idx_reg[1:0]) +: 4]);
                    if (idx_reg == IDX_W'(3)) begin
                        put_last = 1'b1;
                        end_pkt  = 1'b1;
                        idx_next = '0;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase

        hold_next  = ph_next;
        hcnt_next  = ph_cnt;
        trunc_next = ph_trunc;
        if (send_en && state_reg == ST_FLUSH) begin
            hold_next[0] = hold_reg[1];
            hold_next[1] = hold_reg[2];
            hcnt_next    = hcnt_reg - 2'd1;
        end

        out_valid_next = out_valid_reg && !m_ready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        status_next    = status_reg;
        crc_next       = crc_reg;
        if (push_send || send_en) begin
            out_valid_next = 1'b1;
            out_char_next  = push_send ? hold_reg[0] : send_char;
            out_last_next  = 1'b0;
            status_next    = 1'b0;
            crc_next       = crc_byte(crc_reg, push_send ? hold_reg[0] : send_char);
        end else if (put_en) begin
            out_valid_next = 1'b1;
            out_char_next  = put_char;
            out_last_next  = put_last;
            status_next    = put_last && !cur_seen_reg;
        end

        if (end_pkt) begin
            crc_next      = CRC_INIT;
            trunc_next    = 1'b0;
            hcnt_next     = 2'd0;
            cur_seen_next = 1'b0;
            window_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            price_reg     <= '0;
            window_reg    <= '0;
            cur_seen_reg  <= 1'b0;
            trunc_reg     <= 1'b0;
            hcnt_reg      <= 2'd0;
            crc_reg       <= CRC_INIT;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            price_reg     <= price_next;
            window_reg    <= window_next;
            cur_seen_reg  <= cur_seen_next;
            trunc_reg     <= trunc_next;
            hcnt_reg      <= hcnt_next;
            crc_reg       <= crc_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_reg     <= hold_next;
        char_reg     <= char_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        status_reg   <= status_next;
    end

    assign m_valid    = out_valid_reg;
    assign m_out_char = out_char_reg;
    assign m_out_last = out_last_reg;
    assign m_status   = status_reg;

    `QPAIC_ASSERT_NOW(a_trunc_empty, aclk, aresetn, trunc_reg, hcnt_reg == 2'd0)
    `QPAIC_ASSERT_NEXT(a_stall_crc, aclk, aresetn, out_valid_reg && !m_ready, $stable(crc_reg))
    `QPAIC_ASSERT_NOW(a_ins_bcd_done, aclk, aresetn, state_reg == ST_INS, bcd_stat.done)
    `QPAIC_ASSERT_NEXT(a_end_clean, aclk, aresetn, end_pkt,
        crc_reg == CRC_INIT && !cur_seen_reg && state_reg == ST_IDLE && m_out_last)

endmodule

[bench/qpaic_rewrite_checker.sv]
`timescale 1ns / 100ps
module qpaic_rewrite_checker
    import qpaic_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [PRICE_W-1:0] cfg_wr_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [7:0]         s_in_char,
    input  logic               s_in_last,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [7:0]         m_out_char,
    input  logic               m_out_last,
    input  logic               m_status,
    output int                 n_fail,
    output int                 n_pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       st;
    } out_beat_t;

    localparam logic [63:0] AMOUNT_CAP = 64'd10 ** MAX_PRICE_DIGITS - 64'd1;

    out_beat_t          rewritten_q[$];
    logic [PRICE_W-1:0] price;
    logic [47:0]        recent_in;
    logic               tag_found;
    logic               cut_done;
    logic [7:0]         held[3];
    int                 held_n;
    logic [15:0]        crc;

    initial begin
        n_fail    = 0;
        n_pending = 0;
    end

    function automatic logic [15:0] crc_advance(input logic [15:0] v, input logic [7:0] c);
        logic fb;
        for (int k = 7; k >= 0; k--) begin
            fb = v[15] ^ c[k];
            v  = {v[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return v;
    endfunction

    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) begin
            r = 8'h30 + {4'h0, n};
        end else begin
            r = 8'h41 + {4'h0, n} - 8'd10;
        end
        return r;
    endfunction

    task automatic queue_beat(input logic [7:0] c, input logic l, input logic s);
        out_beat_t b;
        b.ch   = c;
        b.last = l;
        b.st   = s;
        rewritten_q.push_back(b);
    endtask

    task automatic emit_crc(input logic [7:0] c);
        crc = crc_advance(crc, c);
        queue_beat(c, 1'b0, 1'b0);
    endtask

    // three chars held back so a "6304" in the edited stream can be cut
    task automatic edit_char(input logic [7:0] c);
        if (!cut_done) begin
            if (held_n == 3) begin
                if (held[0] == CH_6 && held[1] == CH_3 && held[2] == CH_0 && c == CH_4) begin
                    cut_done = 1'b1;
                    held_n   = 0;
                end else begin
                    emit_crc(held[0]);
                    held[0] = held[1];
                    held[1] = held[2];
                    held[2] = c;
                end
            end else begin
                held[held_n] = c;
                held_n++;
            end
        end
    endtask

    task automatic splice_amount();
        logic [63:0] p;
        logic [63:0] r;
        logic [7:0]  dg[20];
        logic [7:0]  tens;
        logic [7:0]  ones;
        int          cnt;
        p   = ({30'd0, price} > AMOUNT_CAP) ? AMOUNT_CAP : {30'd0, price};
        cnt = 0;
        do begin
            r       = p % 64'd10;
            dg[cnt] = CH_0 + r[7:0];
            p       = p / 64'd10;
            cnt++;
        end while (p != 0 && cnt < 20);
        tens = 8'((cnt / 10) % 10);
        ones = 8'(cnt % 10);
        edit_char(CH_5);
        edit_char(CH_4);
        edit_char(CH_0 + tens);
        edit_char(CH_0 + ones);
        while (cnt > 0) begin
            cnt--;
            edit_char(dg[cnt]);
        end
    endtask

    task automatic clear_payload();
        recent_in = '0;
        tag_found = 1'b0;
        held_n    = 0;
        cut_done  = 1'b0;
        crc       = CRC_INIT;
    endtask

    task automatic predict_char(input logic [7:0] c, input logic l);
        logic        hit;
        logic [15:0] sum;
        hit       = !tag_found && recent_in == CUR_PREFIX && c == CUR_FINAL;
        recent_in = {recent_in[39:0], c};
        edit_char(c);
        if (hit) begin
            tag_found = 1'b1;
            splice_amount();
        end
        if (l) begin
            for (int i = 0; i < held_n; i++) begin
                emit_crc(held[i]);
            end
            held_n = 0;
            emit_crc(CH_6);
            emit_crc(CH_3);
            emit_crc(CH_0);
            emit_crc(CH_4);
            sum = crc;
            queue_beat(hex_ascii(sum[15:12]), 1'b0, 1'b0);
            queue_beat(hex_ascii(sum[11:8]), 1'b0, 1'b0);
            queue_beat(hex_ascii(sum[7:4]), 1'b0, 1'b0);
            queue_beat(hex_ascii(sum[3:0]), 1'b1, !tag_found);
            clear_payload();
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [7:0] e, input logic [7:0] a);
        $display("%0t ns: %s expected %h, actual %h", $time, what, e, a);
        n_fail++;
    endtask

    always @(posedge aclk) begin : watch
        out_beat_t want;
        if (!aresetn) begin
            price = '0;
            clear_payload();
            rewritten_q.delete();
        end else begin
            if (cfg_wr_en) begin
                price = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                predict_char(s_in_char, s_in_last);
            end
            if (m_valid && m_ready) begin
                if (rewritten_q.size() == 0) begin
                    $display("%0t ns: unexpected beat, expected none, actual char %h last %b status %b",
                             $time, m_out_char, m_out_last, m_status);
                    n_fail++;
                end else begin
                    want = rewritten_q.pop_front();
                    if (m_out_char !== want.ch) begin
                        flag_mismatch("out_char", want.ch, m_out_char);
                    end
                    if (m_out_last !== want.last) begin
                        flag_mismatch("out_last", {7'd0, want.last}, {7'd0, m_out_last});
                    end
                    if (m_status !== want.st) begin
                        flag_mismatch("status", {7'd0, want.st}, {7'd0, m_status});
                    end
                end
            end
        end
        n_pending = rewritten_q.size();
    end

endmodule

[bench/tb_qr_payload_amount_insert_crc_core.sv]
`timescale 1ns / 100ps
module tb_qr_payload_amount_insert_crc_core
    import qpaic_pkg::*;
();

    logic               aclk        = 1'b0;
    logic               aresetn     = 1'b0;
    logic               cfg_wr_en   = 1'b0;
    logic [PRICE_W-1:0] cfg_wr_data = '0;
    logic               s_valid     = 1'b0;
    logic               s_ready;
    logic [7:0]         s_in_char   = 8'h00;
    logic               s_in_last   = 1'b0;
    logic               m_valid;
    logic               m_ready     = 1'b0;
    logic [7:0]         m_out_char;
    logic               m_out_last;
    logic               m_status;

    int         n_fail;
    int         n_pending;
    int         n_sent     = 0;
    int         burst_left = 1;
    logic [7:0] pay[$];

    always #2 aclk = ~aclk;

    qr_payload_amount_insert_crc_core u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_char   (s_in_char),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_out_last  (m_out_last),
        .m_status    (m_status)
    );

    qpaic_rewrite_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_char   (s_in_char),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_out_last  (m_out_last),
        .m_status    (m_status),
        .n_fail      (n_fail),
        .n_pending   (n_pending)
    );

    initial begin
        #4000000;
        $display("qr_payload_amount_insert_crc_core verification failed");
        $finish;
    end

    // receiver: picks a new random stall mode after each span of random length
    initial begin : rx_stall
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 64);
            repeat (span) begin
                @(posedge aclk);
                case (mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 4) == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            pay.push_back(s[i]);
        end
    endtask

    task automatic add_noise(input int n);
        logic [7:0] c;
        repeat (n) begin
            case ($urandom_range(0, 3))
                0:       c = 8'($urandom_range(0, 255));
                1, 2:    c = 8'($urandom_range(8'h30, 8'h36));
                default: c = 8'($urandom_range(8'h41, 8'h5A));
            endcase
            pay.push_back(c);
        end
    endtask

    task automatic put_char(input logic [7:0] c, input logic l);
        s_valid   <= 1'b1;
        s_in_char <= c;
        s_in_last <= l;
        do @(posedge aclk); while (!s_ready);
        n_sent++;
    endtask

    task automatic feed_payload();
        for (int i = 0; i < pay.size(); i++) begin
            put_char(pay[i], i == pay.size() - 1);
            burst_left--;
            if (burst_left <= 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (n_pending != 0);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_price(input logic [PRICE_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin : stim
        logic [63:0] amt;
        logic [7:0]  odd;
        int          k;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // price still at reset value: zero amount, tag on the last char
        pay.delete();
        add_str("5303360");
        feed_payload();
        pay.delete();
        pay.push_back(8'h00);
        feed_payload();
        pay.delete();
        pay.push_back(8'hFF);
        feed_payload();
        // currency tag only after the cut
        pay.delete();
        add_str("6304");
        add_str("5303360");
        feed_payload();

        settle();
        write_price({PRICE_W{1'b1}});
        pay.delete();
        add_str("5303360");
        feed_payload();

        for (int ph = 0; ph < 10; ph++) begin
            settle();
            case (ph)
                0: amt = 64'd0;
                1: amt = 64'd9999999999;
                2: amt = 64'd10000000000;
                3: amt = 64'd1;
                4: amt = 64'd6304;
                default: begin
                    case ($urandom_range(0, 4))
                        0: amt = {$urandom, $urandom} % (64'd10 ** $urandom_range(1, 10));
                        1: amt = 64'd6304 * (64'd10 ** $urandom_range(0, 5))
                                 + 64'($urandom_range(0, 9));
                        2: amt = {$urandom, $urandom};
                        3: amt = 64'($urandom_range(0, 99));
                        default: amt = 64'h3_FFFF_FFFF - 64'($urandom_range(0, 3));
                    endcase
                end
            endcase
            write_price(amt[PRICE_W-1:0]);

            while (n_sent < 27 + 39 * (ph + 1)) begin
                pay.delete();
                k = $urandom_range(0, 9);
                if (k <= 5) begin
                    add_noise($urandom_range(0, 6));
                    add_str("5303360");
                    add_noise($urandom_range(0, 6));
                    if ($urandom_range(0, 1)) begin
                        add_str("6304");
                        add_noise($urandom_range(0, 4));
                    end
                end else if (k == 6) begin
                    add_noise($urandom_range(1, 12));
                    if ($urandom_range(0, 1)) begin
                        add_str("6304");
                    end
                    add_noise($urandom_range(0, 3));
                end else if (k == 7) begin
                    add_str("530336");
                    odd = 8'($urandom_range(0, 255));
                    pay.push_back((odd == CUR_FINAL) ? CH_1 : odd);
                    add_noise($urandom_range(0, 5));
                end else if (k == 8) begin
                    if ($urandom_range(0, 1)) begin
                        add_str("6304");
                    end
                    add_str("5303360");
                    add_noise($urandom_range(0, 3));
                    add_str("5303360");
                    add_noise($urandom_range(0, 3));
                end else begin
                    repeat ($urandom_range(1, 10)) begin
                        pay.push_back(8'($urandom_range(0, 255)));
                    end
                end
                feed_payload();
            end
        end

        settle();
        @(negedge aclk);
        if (n_fail == 0 && n_pending == 0) begin
            $display("qr_payload_amount_insert_crc_core verification clean");
        end else begin
            $display("qr_payload_amount_insert_crc_core verification failed");
        end
        $finish;
    end

endmodule
